// ===== rtl/nfna_pkg.sv =====
// shared types and constants of the nearest free note slot allocator
`timescale 1ns / 1ps
`default_nettype none

package nfna_pkg;

  // slot field width and the largest slot that the field can name
  localparam int unsigned SLOT_W     = 7;
  localparam int unsigned SLOT_LIMIT = 128;
  localparam logic [SLOT_W-1:0] SLOT_MAX = 7'd127;

  // request operation codes
  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // occupancy memory access: one write port, two read ports
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic              wdata;
    logic [SLOT_W-1:0] raddr_hi;
    logic [SLOT_W-1:0] raddr_lo;
  } occ_port_t;

  // finished result handed to the output register
  typedef struct packed {
    logic              load;
    logic [SLOT_W-1:0] slot;
    logic              no_free;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/nearest_free_note_allocator_core.sv =====
// top level of the nearest free note slot allocator
// Usage:
//   The input channel takes one request per handshake: in_func selects allocate
//   or release and in_slot names the requested slot or the slot to free.
//   Allocate grants the free slot nearest the requested one, trying r, r+1,
//   r-1, r+2, r-2 and so on (ties go to the higher slot); if every slot is in
//   use out_no_free is 1, out_granted_slot echoes the request and nothing
//   changes. Release frees the slot and echoes it.
//   Each request gives exactly one result on the output channel.
//   Timing: the bitmap sits in a memory with two read ports, so the search
//   reads the pair r+d and r-d for one distance d per cycle; a release goes
//   straight to its final state. The next request is taken the cycle after
//   the previous result enters the output register.
//   Reset: a clearing pass writes every bitmap entry free, one per cycle, and
//   in_stall stays high during it.
//   Stall: a result held by out_stall keeps the output register full; a
//   request already taken waits in its final state until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module nearest_free_note_allocator_core #(
  parameter int unsigned NUM_SLOTS = 128
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_func,
  input  wire logic [nfna_pkg::SLOT_W-1:0] in_slot,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [nfna_pkg::SLOT_W-1:0]      out_granted_slot,
  output logic                             out_no_free
);

  localparam int unsigned MAP_DEPTH =
    (NUM_SLOTS > nfna_pkg::SLOT_LIMIT) ? nfna_pkg::SLOT_LIMIT : NUM_SLOTS;

  nfna_pkg::occ_port_t port;
  nfna_pkg::res_t      res;
  logic                rd_hi;
  logic                rd_lo;
  logic                res_ready;

  logic                          out_valid_r, out_valid_nxt;
  logic [nfna_pkg::SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic                          out_nofree_r, out_nofree_nxt;

  // occupancy bitmap
  nfna_occ_mem #(
    .DEPTH(MAP_DEPTH)
  ) u_mem (
    .clk   (clk),
    .port  (port),
    .rd_hi (rd_hi),
    .rd_lo (rd_lo)
  );

  // search and release sequencer
  nfna_ctrl #(
    .DEPTH(MAP_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_func   (in_func),
    .in_slot   (in_slot),
    .rd_hi     (rd_hi),
    .rd_lo     (rd_lo),
    .port      (port),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_slot_nxt   = out_slot_r;
    out_nofree_nxt = out_nofree_r;
    if (res.load) begin
      out_valid_nxt  = 1'b1;
      out_slot_nxt   = res.slot;
      out_nofree_nxt = res.no_free;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_slot_r   <= out_slot_nxt;
    out_nofree_r <= out_nofree_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_granted_slot = out_slot_r;
  assign out_no_free      = out_nofree_r;

endmodule

`default_nettype wire

// ===== rtl/nfna_occ_mem.sv =====
// occupancy bitmap memory with one write port and two registered read ports
`timescale 1ns / 1ps
`default_nettype none

module nfna_occ_mem #(
  parameter int unsigned DEPTH = 128
) (
  input  wire logic               clk,
  input  wire nfna_pkg::occ_port_t port,
  output logic                    rd_hi,
  output logic                    rd_lo
);

  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic mem [DEPTH];
  logic rd_hi_r;
  logic rd_lo_r;

  // write port
  always_ff @(posedge clk) begin
    if (port.we) begin
      mem[port.waddr[ADDR_W-1:0]] <= port.wdata;
    end
  end

  // two synchronous read ports
  always_ff @(posedge clk) begin
    rd_hi_r <= mem[port.raddr_hi[ADDR_W-1:0]];
    rd_lo_r <= mem[port.raddr_lo[ADDR_W-1:0]];
  end

  assign rd_hi = rd_hi_r;
  assign rd_lo = rd_lo_r;

endmodule

`default_nettype wire

// ===== rtl/nfna_ctrl.sv =====
// sequencer: clearing pass, nearest free search over the bitmap, release
`timescale 1ns / 1ps
`default_nettype none

module nfna_ctrl #(
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_func,
  input  wire logic [nfna_pkg::SLOT_W-1:0]   in_slot,
  input  wire logic                          rd_hi,
  input  wire logic                          rd_lo,
  output nfna_pkg::occ_port_t                port,
  input  wire logic                          res_ready,
  output nfna_pkg::res_t                     res
);

  localparam int unsigned SW = nfna_pkg::SLOT_W;

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_SEARCH = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [SW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic [SW-1:0] d_r, d_nxt;
  logic          chk_vld_r, chk_vld_nxt;
  logic [SW-1:0] chk_hi_r, chk_hi_nxt;
  logic          chk_hi_ok_r, chk_hi_ok_nxt;
  logic [SW-1:0] chk_lo_r, chk_lo_nxt;
  logic          chk_lo_ok_r, chk_lo_ok_nxt;
  logic          chk_last_r, chk_last_nxt;
  logic [SW-1:0] fin_slot_r, fin_slot_nxt;
  logic          fin_nofree_r, fin_nofree_nxt;
  logic          fin_we_r, fin_we_nxt;
  logic          fin_wdata_r, fin_wdata_nxt;

  logic [SW:0]   cand_hi;
  logic [SW-1:0] cand_lo;
  logic          hi_ok;
  logic          lo_ok;
  logic          last_d;
  logic          in_range;
  logic          accept;

  // candidates at the current distance
  assign cand_hi  = {1'b0, slot_r} + {1'b0, d_r};
  assign cand_lo  = slot_r - d_r;
  assign hi_ok    = cand_hi < (SW+1)'(DEPTH);
  assign lo_ok    = (d_r != '0) && (slot_r >= d_r) && ({1'b0, cand_lo} < (SW+1)'(DEPTH));
  // past this distance no candidate can come into range
  assign last_d   = (d_r == nfna_pkg::SLOT_MAX) || (!hi_ok && (d_r > slot_r));
  assign in_range = {1'b0, in_slot} < (SW+1)'(DEPTH);

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);

  // next state and datapath
  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    slot_nxt       = slot_r;
    d_nxt          = d_r;
    chk_vld_nxt    = chk_vld_r;
    chk_hi_nxt     = chk_hi_r;
    chk_hi_ok_nxt  = chk_hi_ok_r;
    chk_lo_nxt     = chk_lo_r;
    chk_lo_ok_nxt  = chk_lo_ok_r;
    chk_last_nxt   = chk_last_r;
    fin_slot_nxt   = fin_slot_r;
    fin_nofree_nxt = fin_nofree_r;
    fin_we_nxt     = fin_we_r;
    fin_wdata_nxt  = fin_wdata_r;

    port.we        = 1'b0;
    port.waddr     = fin_slot_r;
    port.wdata     = fin_wdata_r;
    port.raddr_hi  = cand_hi[SW-1:0];
    port.raddr_lo  = cand_lo;

    res.load       = 1'b0;
    res.slot       = fin_slot_r;
    res.no_free    = fin_nofree_r;

    unique case (state_r)
      ST_CLEAR: begin
        port.we     = 1'b1;
        port.waddr  = clr_cnt_r;
        port.wdata  = 1'b0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == SW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          slot_nxt = in_slot;
          if (in_func == nfna_pkg::FUNC_RELEASE) begin
            fin_slot_nxt   = in_slot;
            fin_nofree_nxt = 1'b0;
            fin_we_nxt     = in_range;
            fin_wdata_nxt  = 1'b0;
            state_nxt      = ST_FINISH;
          end else begin
            d_nxt       = '0;
            chk_vld_nxt = 1'b0;
            state_nxt   = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        // check the pair read last cycle, higher slot first
        if (chk_vld_r && chk_hi_ok_r && !rd_hi) begin
          fin_slot_nxt   = chk_hi_r;
          fin_nofree_nxt = 1'b0;
          fin_we_nxt     = 1'b1;
          fin_wdata_nxt  = 1'b1;
          state_nxt      = ST_FINISH;
        end else if (chk_vld_r && chk_lo_ok_r && !rd_lo) begin
          fin_slot_nxt   = chk_lo_r;
          fin_nofree_nxt = 1'b0;
          fin_we_nxt     = 1'b1;
          fin_wdata_nxt  = 1'b1;
          state_nxt      = ST_FINISH;
        end else if (chk_vld_r && chk_last_r) begin
          fin_slot_nxt   = slot_r;
          fin_nofree_nxt = 1'b1;
          fin_we_nxt     = 1'b0;
          fin_wdata_nxt  = 1'b0;
          state_nxt      = ST_FINISH;
        end else begin
          // read the pair at the current distance
          chk_vld_nxt   = 1'b1;
          chk_hi_nxt    = cand_hi[SW-1:0];
          chk_hi_ok_nxt = hi_ok;
          chk_lo_nxt    = cand_lo;
          chk_lo_ok_nxt = lo_ok;
          chk_last_nxt  = last_d;
          d_nxt         = d_r + 1'b1;
        end
      end
      ST_FINISH: begin
        // write back and hand over once the output register is free
        if (res_ready) begin
          port.we   = fin_we_r;
          res.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      chk_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      chk_vld_r <= chk_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    slot_r       <= slot_nxt;
    d_r          <= d_nxt;
    chk_hi_r     <= chk_hi_nxt;
    chk_hi_ok_r  <= chk_hi_ok_nxt;
    chk_lo_r     <= chk_lo_nxt;
    chk_lo_ok_r  <= chk_lo_ok_nxt;
    chk_last_r   <= chk_last_nxt;
    fin_slot_r   <= fin_slot_nxt;
    fin_nofree_r <= fin_nofree_nxt;
    fin_we_r     <= fin_we_nxt;
    fin_wdata_r  <= fin_wdata_nxt;
  end

endmodule

`default_nettype wire

// ===== test/nearest_free_note_allocator_core_tb.sv =====
// self-checking testbench for the nearest free note slot allocator
`timescale 1ns / 1ps

module nearest_free_note_allocator_core_tb;

  localparam int unsigned SW       = nfna_pkg::SLOT_W;
  localparam int          SLOTS    = nfna_pkg::SLOT_LIMIT;
  localparam int          TARGET   = 1500;
  localparam int          DRAIN    = 140;
  localparam int          MAX_SHOW = 10;

  typedef struct {
    logic          func;
    logic [SW-1:0] slot;
  } note_req_t;

  typedef struct {
    logic [SW-1:0] slot;
    logic          no_free;
  } grant_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_func = nfna_pkg::FUNC_ALLOC;
  logic [SW-1:0] in_slot = '0;
  logic          out_stall = 1'b0;
  wire           in_stall;
  wire           out_valid;
  wire [SW-1:0]  out_granted_slot;
  wire           out_no_free;

  note_req_t    pending_reqs[$];
  grant_t       expected_grants[$];
  logic [127:0] slot_busy = '0;
  int           sent_count = 0;
  int           total_requests = 0;
  int           mismatch_count = 0;

  nearest_free_note_allocator_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_slot          (in_slot),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_granted_slot (out_granted_slot),
    .out_no_free      (out_no_free)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // own copy of the occupancy map: grant the free slot nearest the request
  function automatic grant_t predict_grant(logic func, logic [SW-1:0] slot);
    grant_t g;
    int     r;
    int     hit;
    r         = slot;
    hit       = -1;
    g.slot    = slot;
    g.no_free = 1'b0;
    if (func == nfna_pkg::FUNC_RELEASE) begin
      if (r < SLOTS) slot_busy[r] = 1'b0;
      return g;
    end
    // r, r+1, r-1, r+2, r-2 ... higher side first on a tie
    for (int d = 0; d <= SLOTS && hit < 0; d++) begin
      if (r + d < SLOTS && !slot_busy[r + d]) begin
        hit = r + d;
      end else if (d > 0 && r - d >= 0 && !slot_busy[r - d]) begin
        hit = r - d;
      end
    end
    if (hit < 0) begin
      g.no_free = 1'b1;
    end else begin
      slot_busy[hit] = 1'b1;
      g.slot = hit[SW-1:0];
    end
    return g;
  endfunction

  // idle rate per side: sender light first, then heavy, then none
  function automatic int idle_percent(bit sender);
    int ph;
    ph = (total_requests == 0) ? 2 : sent_count * 3 / total_requests;
    case (ph)
      0: return sender ? 28 : 76;
      1: return sender ? 76 : 28;
      default: return 0;
    endcase
  endfunction

  // slot choice leaning towards the ends of the range
  function automatic logic [SW-1:0] pick_slot();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return SW'(SLOTS - 1);
      2: return SW'($urandom_range(0, 3));
      3: return SW'($urandom_range(SLOTS - 4, SLOTS - 1));
      default: return SW'($urandom_range(0, SLOTS - 1));
    endcase
  endfunction

  task automatic queue_request(logic func, logic [SW-1:0] slot);
    note_req_t q;
    q.func = func;
    q.slot = slot;
    pending_reqs.insert(pending_reqs.size(), q);
  endtask

  // request driver
  always @(posedge clk) begin : request_driver
    logic      taken;
    note_req_t q;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      taken = in_valid && !in_stall;
      if (taken) begin
        expected_grants.insert(expected_grants.size(), predict_grant(in_func, in_slot));
        sent_count++;
      end
      // a stalled request stays as it is
      if (!(in_valid && !taken)) begin
        if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= idle_percent(1'b1)) begin
          q = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_func  <= q.func;
          in_slot  <= q.slot;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : grant_monitor
    grant_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_grants.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_SHOW)
          $display("unexpected result: slot %0d no_free %0b", out_granted_slot, out_no_free);
      end else begin
        want = expected_grants.pop_front();
        if (out_granted_slot !== want.slot || out_no_free !== want.no_free) begin
          mismatch_count++;
          if (mismatch_count <= MAX_SHOW)
            $display("mismatch: expected slot %0d no_free %0b, got slot %0d no_free %0b",
                     want.slot, want.no_free, out_granted_slot, out_no_free);
        end
      end
    end
    out_stall <= rst_n && ($urandom_range(0, 99) < idle_percent(1'b0));
  end

  // stimulus and end of run
  initial begin : stimulus
    int            n;
    int            k;
    int            s;
    logic [SW-1:0] centre;

    // directed: ends of the range, ties, double release, echo on release
    queue_request(nfna_pkg::FUNC_ALLOC, 7'd0);
    queue_request(nfna_pkg::FUNC_ALLOC, 7'd0);
    queue_request(nfna_pkg::FUNC_ALLOC, 7'd127);
    queue_request(nfna_pkg::FUNC_ALLOC, 7'd127);
    queue_request(nfna_pkg::FUNC_ALLOC, 7'd85);
    queue_request(nfna_pkg::FUNC_ALLOC, 7'd85);
    queue_request(nfna_pkg::FUNC_ALLOC, 7'd85);
    queue_request(nfna_pkg::FUNC_ALLOC, 7'd85);
    queue_request(nfna_pkg::FUNC_ALLOC, 7'd42);
    queue_request(nfna_pkg::FUNC_RELEASE, 7'd42);
    queue_request(nfna_pkg::FUNC_RELEASE, 7'd42);
    queue_request(nfna_pkg::FUNC_RELEASE, 7'd127);
    queue_request(nfna_pkg::FUNC_ALLOC, 7'd126);
    queue_request(nfna_pkg::FUNC_RELEASE, 7'd0);
    queue_request(nfna_pkg::FUNC_RELEASE, 7'd1);
    queue_request(nfna_pkg::FUNC_ALLOC, 7'd1);
    queue_request(nfna_pkg::FUNC_ALLOC, 7'd0);

    // random sequences, mostly filling, clustering and draining the map
    while (pending_reqs.size() < TARGET) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // fill past full so that allocates meet a map with no free slot
          n = $urandom_range(130, 140);
          repeat (n) queue_request(nfna_pkg::FUNC_ALLOC, pick_slot());
          n = $urandom_range(16, SLOTS);
          repeat (n) queue_request(nfna_pkg::FUNC_RELEASE, pick_slot());
        end
        3, 4, 5: begin
          // crowd one region, then thin it out
          centre = pick_slot();
          n = $urandom_range(8, 40);
          for (k = 0; k < n; k++) begin
            s = int'(centre) + $urandom_range(0, 8) - 4;
            if (s < 0) s = 0;
            if (s > SLOTS - 1) s = SLOTS - 1;
            queue_request(nfna_pkg::FUNC_ALLOC, SW'(s));
          end
          for (k = 0; k < n / 2; k++) begin
            s = int'(centre) + $urandom_range(0, 24) - 12;
            if (s < 0) s = 0;
            if (s > SLOTS - 1) s = SLOTS - 1;
            queue_request(nfna_pkg::FUNC_RELEASE, SW'(s));
          end
        end
        6, 7: begin
          repeat (30)
            queue_request(logic'($urandom_range(0, 1)), SW'($urandom_range(0, SLOTS - 1)));
        end
        8: begin
          // free every slot, starting anywhere
          s = $urandom_range(0, SLOTS - 1);
          for (k = 0; k < SLOTS; k++)
            queue_request(nfna_pkg::FUNC_RELEASE, SW'((s + k) % SLOTS));
        end
        default: begin
          repeat (10) begin
            centre = pick_slot();
            queue_request(nfna_pkg::FUNC_ALLOC, centre);
            queue_request(nfna_pkg::FUNC_RELEASE, centre);
          end
        end
      endcase
    end
    // keep the request count at the target
    while (pending_reqs.size() > TARGET)
      void'(pending_reqs.pop_back());
    total_requests = pending_reqs.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() > 0 || in_valid || expected_grants.size() > 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (mismatch_count == 0 && expected_grants.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // run time limit
  initial begin : watchdog
    #6ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/nfna_pkg.sv
rtl/nfna_occ_mem.sv
rtl/nfna_ctrl.sv
rtl/nearest_free_note_allocator_core.sv
test/nearest_free_note_allocator_core_tb.sv
